[src/crps_pkg.sv]
package crps_pkg;

    localparam int COORD_W = 32;

    // Most jobs a single waypoint can produce: two segments and the final point.
    localparam int MAX_JOBS = 3;

    // Job queue between the front and back ends. The depth must be a power of two.
    localparam int JQ_DEPTH = 4;
    localparam int JQ_PTR_W = 2;
    localparam int JQ_CNT_W = 3;

    // Result queue at the output. The depth must be a power of two.
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = 3;
    localparam int OUT_CNT_W = 4;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } pt_t;

    // A direct job emits p1 once. Any other job is a segment of Catmull-Rom points.
    typedef struct packed {
        logic direct;
        logic eop;
        pt_t  p0;
        pt_t  p1;
        pt_t  p2;
        pt_t  p3;
    } job_t;

    typedef struct packed {
        logic [1:0]                count;
        job_t [MAX_JOBS-1:0]       jobs;
    } job_wr_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   eop;
    } res_t;

    function automatic job_t make_point(input pt_t p, input logic eop);
        job_t j;
        j        = '0;
        j.direct = 1'b1;
        j.eop    = eop;
        j.p1     = p;
        return j;
    endfunction

    function automatic job_t make_segment(input pt_t a, input pt_t b, input pt_t c,
                                          input pt_t d);
        job_t j;
        j.direct = 1'b0;
        j.eop    = 1'b0;
        j.p0     = a;
        j.p1     = b;
        j.p2     = c;
        j.p3     = d;
        return j;
    endfunction

endpackage

[src/crps_front.sv]
module crps_front #(
    parameter int DECIMATION_STRIDE = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [31:0]            point_x,
    input  logic signed [31:0]            point_y,
    input  logic                          final_point,
    input  logic [crps_pkg::JQ_CNT_W-1:0] free,
    output crps_pkg::job_wr_t             wr
);

    localparam int PH_W = (DECIMATION_STRIDE > 1) ? $clog2(DECIMATION_STRIDE) : 1;

    crps_pkg::pt_t   win_reg [3];
    crps_pkg::pt_t   win_next [3];
    crps_pkg::pt_t   win_p [3];
    crps_pkg::pt_t   early_reg [3];
    logic [PH_W-1:0] phase_reg, phase_next;
    logic [2:0]      raw_reg, raw_next;
    logic [1:0]      ctl_reg, ctl_next;

    crps_pkg::pt_t   p;
    crps_pkg::job_t  job_a, job_b;
    logic            accept;
    logic            push_ctl;
    logic            seg_a, seg_b;
    logic [1:0]      ctl_p;
    logic [1:0]      n;

    assign full   = free < crps_pkg::JQ_CNT_W'(crps_pkg::MAX_JOBS);
    assign accept = push && !full;
    assign p      = {point_x, point_y};

    // On the last waypoint a repeat of the newest control is not kept again, unless it falls on the stride.
    always_comb
    begin
        if (final_point)
        begin
            push_ctl = (phase_reg == '0) || (ctl_reg == 2'd0) || (p != win_reg[2]);
        end
        else
        begin
            push_ctl = (phase_reg == '0);
        end
        win_p[0] = push_ctl ? win_reg[1] : win_reg[0];
        win_p[1] = push_ctl ? win_reg[2] : win_reg[1];
        win_p[2] = push_ctl ? p          : win_reg[2];
        ctl_p    = (push_ctl && ctl_reg != 2'd3) ? ctl_reg + 2'd1 : ctl_reg;
        seg_a    = push_ctl && (ctl_reg >= 2'd2);
        seg_b    = ctl_p >= 2'd2;
        job_a    = crps_pkg::make_segment((ctl_reg == 2'd3) ? win_reg[0] : win_reg[1],
                                          win_reg[1], win_reg[2], p);
        job_b    = crps_pkg::make_segment((ctl_p == 2'd3) ? win_p[0] : win_p[1],
                                          win_p[1], win_p[2], win_p[2]);
    end

    always_comb
    begin
        win_next   = win_reg;
        phase_next = phase_reg;
        raw_next   = raw_reg;
        ctl_next   = ctl_reg;
        wr         = '0;
        n          = 2'd0;
        if (accept)
        begin
            if (!final_point)
            begin
                if (raw_reg != 3'd4)
                begin
                    raw_next = raw_reg + 3'd1;
                end
                win_next = win_p;
                ctl_next = ctl_p;
                if (phase_reg == PH_W'(DECIMATION_STRIDE - 1))
                begin
                    phase_next = '0;
                end
                else
                begin
                    phase_next = phase_reg + PH_W'(1);
                end
                wr.jobs[0] = job_a;
                wr.count   = {1'b0, seg_a};
            end
            else
            begin
                if (raw_reg < 3'd3)
                begin
                    // Short path: the stored waypoints go out unchanged.
                    wr.jobs[0] = (raw_reg == 3'd0) ? crps_pkg::make_point(p, 1'b1)
                                                   : crps_pkg::make_point(early_reg[0], 1'b0);
                    wr.jobs[1] = (raw_reg == 3'd1) ? crps_pkg::make_point(p, 1'b1)
                                                   : crps_pkg::make_point(early_reg[1], 1'b0);
                    wr.jobs[2] = crps_pkg::make_point(p, 1'b1);
                    wr.count   = raw_reg[1:0] + 2'd1;
                end
                else
                begin
                    if (seg_a)
                    begin
                        wr.jobs[n] = job_a;
                        n          = n + 2'd1;
                    end
                    if (seg_b)
                    begin
                        wr.jobs[n] = job_b;
                        n          = n + 2'd1;
                    end
                    wr.jobs[n] = crps_pkg::make_point(p, 1'b1);
                    wr.count   = n + 2'd1;
                end
                win_next[0] = '0;
                win_next[1] = '0;
                win_next[2] = '0;
                phase_next  = '0;
                raw_next    = 3'd0;
                ctl_next    = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg[0] <= '0;
            win_reg[1] <= '0;
            win_reg[2] <= '0;
            phase_reg  <= '0;
            raw_reg    <= 3'd0;
            ctl_reg    <= 2'd0;
        end
        else
        begin
            win_reg   <= win_next;
            phase_reg <= phase_next;
            raw_reg   <= raw_next;
            ctl_reg   <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !final_point && raw_reg < 3'd3)
        begin
            early_reg[raw_reg[1:0]] <= p;
        end
    end

endmodule

[src/crps_jobq.sv]
module crps_jobq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  crps_pkg::job_wr_t             wr,
    output logic [crps_pkg::JQ_CNT_W-1:0] free,
    output crps_pkg::job_t                head,
    output logic                          valid,
    input  logic                          pop
);

    crps_pkg::job_t                 mem_reg [crps_pkg::JQ_DEPTH];
    logic [crps_pkg::JQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [crps_pkg::JQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [crps_pkg::JQ_CNT_W-1:0]  cnt_reg, cnt_next;

    assign valid = cnt_reg != '0;
    assign free  = crps_pkg::JQ_CNT_W'(crps_pkg::JQ_DEPTH) - cnt_reg;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + crps_pkg::JQ_PTR_W'(wr.count);
        rd_ptr_next = rd_ptr_reg + crps_pkg::JQ_PTR_W'(pop);
        cnt_next    = cnt_reg + crps_pkg::JQ_CNT_W'(wr.count)
                      - crps_pkg::JQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Up to three jobs land in consecutive slots in one beat.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < crps_pkg::MAX_JOBS; i++)
        begin
            if (2'(i) < wr.count)
            begin
                mem_reg[wr_ptr_reg + crps_pkg::JQ_PTR_W'(i)] <= wr.jobs[i];
            end
        end
    end

endmodule

[src/crps_back.sv]
module crps_back #(
    parameter int STEPS_PER_SEGMENT = 10,
    parameter int FRACTION_BITS     = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  crps_pkg::job_t                 job,
    input  logic                           job_valid,
    output logic                           job_pop,
    input  logic [crps_pkg::OUT_CNT_W-1:0] out_count,
    output logic                           res_valid,
    output crps_pkg::res_t                 res
);

    localparam int K_W = $clog2(STEPS_PER_SEGMENT);
    localparam int WW  = FRACTION_BITS + 2;
    localparam int PW  = crps_pkg::COORD_W + WW;
    localparam int SW  = PW + 1;
    localparam int AW  = PW + 2;

    localparam logic signed [WW-1:0] ONE_W = WW'(longint'(1) << FRACTION_BITS);
    localparam logic signed [AW-1:0] HALF  = AW'(longint'(1) << (FRACTION_BITS - 1));
    localparam logic signed [AW-1:0] MAXV  = AW'(longint'(2147483647));
    localparam logic signed [AW-1:0] MINV  = AW'(-64'sd2147483648);

    logic signed [WW-1:0] wtab [STEPS_PER_SEGMENT][4];
    logic signed [WW-1:0] w [4];

    logic [K_W-1:0]       k_reg, k_next;
    logic                 v1_reg, v2_reg, v3_reg;
    logic                 eop1_reg, eop2_reg, eop3_reg;
    logic signed [PW-1:0] prx_reg [4];
    logic signed [PW-1:0] pry_reg [4];
    logic signed [SW-1:0] ax_reg, bx_reg, ay_reg, by_reg;
    logic signed [AW-1:0] accx_reg, accy_reg;

    logic                 issue, last;
    logic [1:0]           inflight;

    // Basis weights for every step, rounded to nearest with ties away from zero.
    for (genvar k = 0; k < STEPS_PER_SEGMENT; k++)
    begin : g_wt
        localparam longint S   = STEPS_PER_SEGMENT;
        localparam longint K   = k;
        localparam longint DEN = 2 * S * S * S;
        localparam longint ONE = longint'(1) << FRACTION_BITS;
        localparam longint N0  = -K * S * S + 2 * K * K * S - K * K * K;
        localparam longint N1  = 2 * S * S * S - 5 * K * K * S + 3 * K * K * K;
        localparam longint N2  = K * S * S + 4 * K * K * S - 3 * K * K * K;
        localparam longint N3  = -K * K * S + K * K * K;
        localparam longint W0  = (N0 < 0) ? -(((-N0) * ONE + DEN / 2) / DEN)
                                          : ((N0 * ONE + DEN / 2) / DEN);
        localparam longint W1  = (N1 < 0) ? -(((-N1) * ONE + DEN / 2) / DEN)
                                          : ((N1 * ONE + DEN / 2) / DEN);
        localparam longint W2  = (N2 < 0) ? -(((-N2) * ONE + DEN / 2) / DEN)
                                          : ((N2 * ONE + DEN / 2) / DEN);
        localparam longint W3  = (N3 < 0) ? -(((-N3) * ONE + DEN / 2) / DEN)
                                          : ((N3 * ONE + DEN / 2) / DEN);
        assign wtab[k][0] = WW'(W0);
        assign wtab[k][1] = WW'(W1);
        assign wtab[k][2] = WW'(W2);
        assign wtab[k][3] = WW'(W3);
    end

    function automatic crps_pkg::coord_t saturate(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0] s;
        s = acc >>> FRACTION_BITS;
        if (s > MAXV)
        begin
            return crps_pkg::coord_t'(MAXV);
        end
        else if (s < MINV)
        begin
            return crps_pkg::coord_t'(MINV);
        end
        return s[crps_pkg::COORD_W-1:0];
    endfunction

    // Issue only when the result queue has room for this beat and all in flight.
    assign inflight = {1'b0, v1_reg} + {1'b0, v2_reg} + {1'b0, v3_reg};
    assign issue    = job_valid &&
                      ((crps_pkg::OUT_CNT_W + 1)'(out_count) +
                       (crps_pkg::OUT_CNT_W + 1)'(inflight) <
                       (crps_pkg::OUT_CNT_W + 1)'(crps_pkg::OUT_DEPTH));
    assign last     = job.direct || (k_reg == K_W'(STEPS_PER_SEGMENT - 1));
    assign job_pop  = issue && last;

    always_comb
    begin
        k_next = k_reg;
        if (issue)
        begin
            k_next = last ? '0 : k_reg + K_W'(1);
        end
    end

    // A direct point passes with unit weight on p1, which reproduces it exactly.
    always_comb
    begin
        if (job.direct)
        begin
            w[0] = '0;
            w[1] = ONE_W;
            w[2] = '0;
            w[3] = '0;
        end
        else
        begin
            w = wtab[k_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg  <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            k_reg  <= k_next;
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prx_reg[0] <= $signed(job.p0.x) * w[0];
        prx_reg[1] <= $signed(job.p1.x) * w[1];
        prx_reg[2] <= $signed(job.p2.x) * w[2];
        prx_reg[3] <= $signed(job.p3.x) * w[3];
        pry_reg[0] <= $signed(job.p0.y) * w[0];
        pry_reg[1] <= $signed(job.p1.y) * w[1];
        pry_reg[2] <= $signed(job.p2.y) * w[2];
        pry_reg[3] <= $signed(job.p3.y) * w[3];
        eop1_reg   <= job.eop && job.direct;

        ax_reg   <= SW'(prx_reg[0]) + SW'(prx_reg[1]);
        bx_reg   <= SW'(prx_reg[2]) + SW'(prx_reg[3]);
        ay_reg   <= SW'(pry_reg[0]) + SW'(pry_reg[1]);
        by_reg   <= SW'(pry_reg[2]) + SW'(pry_reg[3]);
        eop2_reg <= eop1_reg;

        accx_reg <= AW'(ax_reg) + AW'(bx_reg) + HALF;
        accy_reg <= AW'(ay_reg) + AW'(by_reg) + HALF;
        eop3_reg <= eop2_reg;
    end

    assign res_valid = v3_reg;
    assign res.x     = saturate(accx_reg);
    assign res.y     = saturate(accy_reg);
    assign res.eop   = eop3_reg;

endmodule

[src/crps_outq.sv]
module crps_outq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  crps_pkg::res_t                 wr_data,
    output logic [crps_pkg::OUT_CNT_W-1:0] count,
    output logic                           empty,
    input  logic                           pop,
    output crps_pkg::res_t                 rd_data
);

    crps_pkg::res_t                 mem_reg [crps_pkg::OUT_DEPTH];
    logic [crps_pkg::OUT_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [crps_pkg::OUT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           rd_en;

    assign rd_en   = pop && !empty;
    assign empty   = cnt_reg == '0;
    assign count   = cnt_reg;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg + crps_pkg::OUT_CNT_W'(wr_en) - crps_pkg::OUT_CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + crps_pkg::OUT_PTR_W'(wr_en);
            rd_ptr_reg <= rd_ptr_reg + crps_pkg::OUT_PTR_W'(rd_en);
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[src/catmull_rom_path_smoother_unit.sv]
// Catmull-Rom path smoother. Waypoints enter through a queue-like port; every
// DECIMATION_STRIDE-th one becomes a control point, and each control after the
// second queues a segment of STEPS_PER_SEGMENT smoothed points. A waypoint is
// taken while the four-entry job queue has at least three free slots; full
// rises otherwise. The back end has one multiply-add datapath that produces one
// result per cycle while a job is queued and the output queue has room, so a
// segment holds it until all STEPS_PER_SEGMENT of its points are issued. A result
// passes the product, pair-sum and rounded-sum registers before it is written to
// the output queue. end_of_path marks the last beat of each path.
module catmull_rom_path_smoother_unit #(
    parameter int DECIMATION_STRIDE = 3,
    parameter int STEPS_PER_SEGMENT = 10,
    parameter int FRACTION_BITS     = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic               final_point,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic               end_of_path
);

    crps_pkg::job_wr_t              jq_wr;
    logic [crps_pkg::JQ_CNT_W-1:0]  jq_free;
    crps_pkg::job_t                 jq_head;
    logic                           jq_valid;
    logic                           jq_pop;
    logic [crps_pkg::OUT_CNT_W-1:0] oq_count;
    logic                           res_valid;
    crps_pkg::res_t                 res;
    crps_pkg::res_t                 oq_data;

    crps_front #(
        .DECIMATION_STRIDE (DECIMATION_STRIDE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .point_x     (point_x),
        .point_y     (point_y),
        .final_point (final_point),
        .free        (jq_free),
        .wr          (jq_wr)
    );

    crps_jobq u_jobq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (jq_wr),
        .free  (jq_free),
        .head  (jq_head),
        .valid (jq_valid),
        .pop   (jq_pop)
    );

    crps_back #(
        .STEPS_PER_SEGMENT (STEPS_PER_SEGMENT),
        .FRACTION_BITS     (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (jq_head),
        .job_valid (jq_valid),
        .job_pop   (jq_pop),
        .out_count (oq_count),
        .res_valid (res_valid),
        .res       (res)
    );

    crps_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .count   (oq_count),
        .empty   (empty),
        .pop     (pop),
        .rd_data (oq_data)
    );

    assign out_x       = oq_data.x;
    assign out_y       = oq_data.y;
    assign end_of_path = oq_data.eop;

    a_jobs_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (jq_wr.count != 2'd0) |-> (push && !full))
        else $error("jobs queued without an accepted input beat");

    a_one_job_per_plain_point: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !final_point) |-> (jq_wr.count <= 2'd1))
        else $error("a non-final waypoint queued more than one job");

    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        jq_pop |-> jq_valid)
        else $error("back end retired a job from an empty queue");

    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (oq_count < crps_pkg::OUT_CNT_W'(crps_pkg::OUT_DEPTH) || (pop && !empty)))
        else $error("result written into a full output queue");

endmodule

[dv/catmull_rom_path_smoother_unit_test.sv]
`timescale 1ns / 1ps

module catmull_rom_path_smoother_unit_test;

    localparam int STRIDE = 3;
    localparam int STEPS  = 10;
    localparam int FRAC   = 16;

    localparam crps_pkg::coord_t C_MAX = 32'sh7fff_ffff;
    localparam crps_pkg::coord_t C_MIN = 32'sh8000_0000;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_WAYPOINTS = 140;
    localparam int TAIL_CYCLES      = 20;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             push        = 1'b0;
    logic             full;
    crps_pkg::coord_t point_x     = '0;
    crps_pkg::coord_t point_y     = '0;
    logic             final_point = 1'b0;
    logic             empty;
    logic             pop         = 1'b0;
    crps_pkg::coord_t out_x;
    crps_pkg::coord_t out_y;
    logic             end_of_path;

    catmull_rom_path_smoother_unit #(
        .DECIMATION_STRIDE(STRIDE),
        .STEPS_PER_SEGMENT(STEPS),
        .FRACTION_BITS    (FRAC)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .point_x    (point_x),
        .point_y    (point_y),
        .final_point(final_point),
        .empty      (empty),
        .pop        (pop),
        .out_x      (out_x),
        .out_y      (out_y),
        .end_of_path(end_of_path)
    );

    typedef struct {
        crps_pkg::coord_t x;
        crps_pkg::coord_t y;
        logic             fin;
        bit               fixed;
        crps_pkg::coord_t want_x;
        crps_pkg::coord_t want_y;
    } dir_row_t;

    dir_row_t dir_rows[$];

    // Smoother state as the block should hold it.
    crps_pkg::pt_t ctl_win[3];
    crps_pkg::pt_t head_pts[3];
    int unsigned   stride_pos;
    int unsigned   wp_count;
    int unsigned   ctl_count;

    longint basis_wt[4][STEPS];

    crps_pkg::res_t smooth_exp[$];

    int errors      = 0;
    int n_waypoints = 0;
    int n_paths     = 0;
    int n_checked   = 0;
    int burst_left  = 4;
    int rush_left   = 0;
    bit hold_req    = 1'b0;

    crps_pkg::coord_t walk_x = '0;
    crps_pkg::coord_t walk_y = '0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("FAIL catmull_rom_path_smoother_unit");
        $finish;
    end

    function automatic longint fix_weight(input longint num);
        longint den;
        longint mag;
        longint q;
        den = 2 * STEPS * STEPS * STEPS;
        mag = (num < 0) ? -num : num;
        q   = (mag * (64'sd1 <<< FRAC) + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic void init_weights();
        longint s;
        longint k;
        longint k2;
        longint k3;
        s = STEPS;
        for (int i = 0; i < STEPS; i++)
        begin
            k  = i;
            k2 = k * k;
            k3 = k2 * k;
            basis_wt[0][i] = fix_weight(-k * s * s + 2 * k2 * s - k3);
            basis_wt[1][i] = fix_weight(2 * s * s * s - 5 * k2 * s + 3 * k3);
            basis_wt[2][i] = fix_weight(k * s * s + 4 * k2 * s - 3 * k3);
            basis_wt[3][i] = fix_weight(-k2 * s + k3);
        end
    endfunction

    // Weighted sum, rounded half up, then clamped to the coordinate range.
    function automatic crps_pkg::coord_t blend(input int k,
                                               input crps_pkg::coord_t a,
                                               input crps_pkg::coord_t b,
                                               input crps_pkg::coord_t c,
                                               input crps_pkg::coord_t d);
        longint acc;
        longint v;
        acc = basis_wt[0][k] * a + basis_wt[1][k] * b + basis_wt[2][k] * c
            + basis_wt[3][k] * d;
        v = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        if (v > 64'sd2147483647)
            return C_MAX;
        if (v < -64'sd2147483648)
            return C_MIN;
        return crps_pkg::coord_t'(v);
    endfunction

    function automatic void clear_path();
        for (int i = 0; i < 3; i++)
            ctl_win[i] = '0;
        stride_pos = 0;
        wp_count   = 0;
        ctl_count  = 0;
    endfunction

    task automatic emit_segment(input crps_pkg::pt_t a, input crps_pkg::pt_t b,
                                input crps_pkg::pt_t c, input crps_pkg::pt_t d,
                                ref crps_pkg::res_t outs[$]);
        crps_pkg::res_t r;
        for (int k = 0; k < STEPS; k++)
        begin
            r.x   = blend(k, a.x, b.x, c.x, d.x);
            r.y   = blend(k, a.y, b.y, c.y, d.y);
            r.eop = 1'b0;
            outs.insert(outs.size(), r);
        end
    endtask

    task automatic add_control(input crps_pkg::pt_t c, ref crps_pkg::res_t outs[$]);
        if (ctl_count >= 2)
            emit_segment((ctl_count >= 3) ? ctl_win[0] : ctl_win[1], ctl_win[1],
                         ctl_win[2], c, outs);
        ctl_win[0] = ctl_win[1];
        ctl_win[1] = ctl_win[2];
        ctl_win[2] = c;
        if (ctl_count < 3)
            ctl_count++;
    endtask

    task automatic predict_waypoint(input crps_pkg::pt_t p, input logic fin,
                                    ref crps_pkg::res_t outs[$]);
        crps_pkg::res_t r;
        if (!fin)
        begin
            if (wp_count < 3)
                head_pts[wp_count] = p;
            if (wp_count < 4)
                wp_count++;
            if (stride_pos == 0)
                add_control(p, outs);
            stride_pos = (stride_pos + 1 >= STRIDE) ? 0 : stride_pos + 1;
        end
        else if (wp_count < 3)
        begin
            // Short path: the stored waypoints come out untouched.
            for (int i = 0; i < wp_count; i++)
            begin
                r.x   = head_pts[i].x;
                r.y   = head_pts[i].y;
                r.eop = 1'b0;
                outs.insert(outs.size(), r);
            end
            r.x   = p.x;
            r.y   = p.y;
            r.eop = 1'b1;
            outs.insert(outs.size(), r);
            clear_path();
        end
        else
        begin
            // A final waypoint that repeats the newest control is not kept again, unless it falls on the stride.
            if (stride_pos == 0 || ctl_count == 0 || p != ctl_win[2])
                add_control(p, outs);
            if (ctl_count >= 2)
                emit_segment((ctl_count >= 3) ? ctl_win[0] : ctl_win[1], ctl_win[1],
                             ctl_win[2], ctl_win[2], outs);
            r.x   = p.x;
            r.y   = p.y;
            r.eop = 1'b1;
            outs.insert(outs.size(), r);
            clear_path();
        end
    endtask

    function automatic void add_row(input crps_pkg::coord_t x, input crps_pkg::coord_t y,
                                    input logic fin, input bit fixed,
                                    input crps_pkg::coord_t want_x,
                                    input crps_pkg::coord_t want_y);
        dir_row_t row;
        row.x      = x;
        row.y      = y;
        row.fin    = fin;
        row.fixed  = fixed;
        row.want_x = want_x;
        row.want_y = want_y;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic crps_pkg::coord_t next_coord(input crps_pkg::coord_t cur);
        case ($urandom_range(0, 9))
            0: return crps_pkg::coord_t'($urandom);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return C_MAX;
                    1: return C_MIN;
                    2: return '0;
                    default: return -32'sd1;
                endcase
            end
            default: return cur + crps_pkg::coord_t'($urandom_range(0, 32'h0020_0000))
                            - 32'sh0010_0000;
        endcase
    endfunction

    // Offers one waypoint and holds it until the block takes it.
    task automatic send_waypoint(input crps_pkg::coord_t x, input crps_pkg::coord_t y,
                                 input logic fin, input bit fixed,
                                 input crps_pkg::coord_t want_x,
                                 input crps_pkg::coord_t want_y);
        crps_pkg::pt_t  p;
        crps_pkg::res_t outs[$];
        crps_pkg::res_t fixed_r;
        int             gap;
        push        <= 1'b1;
        point_x     <= x;
        point_y     <= y;
        final_point <= fin;
        do
            @(posedge clk);
        while (full);
        n_waypoints++;
        if (fin)
            n_paths++;
        p.x = x;
        p.y = y;
        predict_waypoint(p, fin, outs);
        if (fixed)
        begin
            fixed_r.x   = want_x;
            fixed_r.y   = want_y;
            fixed_r.eop = 1'b1;
            smooth_exp.insert(smooth_exp.size(), fixed_r);
        end
        else
            foreach (outs[i])
                smooth_exp.insert(smooth_exp.size(), outs[i]);
        if (rush_left > 0)
            rush_left--;
        else if (--burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(1, 6);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic check_point(input crps_pkg::coord_t x, input crps_pkg::coord_t y,
                               input logic eop);
        crps_pkg::res_t w;
        if (smooth_exp.size() == 0)
        begin
            errors++;
            $display("%0t: point with nothing expected: x=%0d y=%0d eop=%0b",
                     $time, x, y, eop);
            return;
        end
        w = smooth_exp.pop_front();
        n_checked++;
        if (x !== w.x)
        begin
            errors++;
            $display("%0t: out_x expected %0d, got %0d", $time, w.x, x);
        end
        if (y !== w.y)
        begin
            errors++;
            $display("%0t: out_y expected %0d, got %0d", $time, w.y, y);
        end
        if (eop !== w.eop)
        begin
            errors++;
            $display("%0t: end_of_path expected %0b, got %0b", $time, w.eop, eop);
        end
    endtask

    // Receiver: cycles through steady, random and sparse pop patterns, and
    // honors one long hold-off on request.
    initial
    begin
        int rx_cycle;
        int hold_left;
        rx_cycle  = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (pop && !empty)
                    check_point(out_x, out_y, end_of_path);
                rx_cycle++;
                if (hold_left > 0)
                begin
                    hold_left--;
                    pop <= 1'b0;
                end
                else if (hold_req)
                begin
                    hold_req  = 1'b0;
                    hold_left = LONG_HOLD_CYCLES;
                    pop <= 1'b0;
                end
                else
                begin
                    case ((rx_cycle / 80) % 4)
                        0: pop <= 1'b1;
                        1: pop <= 1'($urandom_range(0, 1));
                        2: pop <= (rx_cycle % 5 == 0);
                        default: pop <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    initial
    begin
        int               n_rand;
        int               plen;
        int               pidx;
        crps_pkg::coord_t wx;
        crps_pkg::coord_t wy;

        init_weights();
        clear_path();
        for (int i = 0; i < 3; i++)
            head_pts[i] = '0;

        // Single-waypoint paths come back as they went in.
        add_row(C_MAX, C_MIN, 1'b1, 1'b1, C_MAX, C_MIN);
        add_row(C_MIN, C_MAX, 1'b1, 1'b1, C_MIN, C_MAX);
        add_row('0, -32'sd1, 1'b1, 1'b1, '0, -32'sd1);
        // Short paths of three and two waypoints.
        add_row(32'sh0001_0000, 32'sh0002_0000, 1'b0, 1'b0, '0, '0);
        add_row(-32'sh0001_0000, 32'sh7fff_0000, 1'b0, 1'b0, '0, '0);
        add_row(32'sh1234_5678, -32'sh0dea_0001, 1'b1, 1'b0, '0, '0);
        add_row(32'sh5555_5555, 32'shaaaa_aaaa, 1'b0, 1'b0, '0, '0);
        add_row(32'shaaaa_aaaa, 32'sh5555_5555, 1'b1, 1'b0, '0, '0);
        // Final waypoint repeats the newest control, so only the end segment follows.
        add_row('0, '0, 1'b0, 1'b0, '0, '0);
        add_row(32'sh0001_0000, 32'sh0000_8000, 1'b0, 1'b0, '0, '0);
        add_row(32'sh0002_0000, 32'sh0001_0000, 1'b0, 1'b0, '0, '0);
        add_row(32'sh0003_0000, 32'sh0003_0000, 1'b0, 1'b0, '0, '0);
        add_row(32'sh0003_0000, 32'sh0003_0000, 1'b1, 1'b0, '0, '0);
        // Controls swing rail to rail, so the curve overshoots and saturates.
        add_row(C_MIN, C_MAX, 1'b0, 1'b0, '0, '0);
        add_row(32'sh0001_8000, -32'sh0002_0000, 1'b0, 1'b0, '0, '0);
        add_row('0, '0, 1'b0, 1'b0, '0, '0);
        add_row(C_MAX, C_MIN, 1'b0, 1'b0, '0, '0);
        add_row(-32'sd1, 32'sd1, 1'b0, 1'b0, '0, '0);
        add_row(32'sh4000_0000, -32'sh4000_0000, 1'b0, 1'b0, '0, '0);
        add_row(C_MAX, C_MIN, 1'b0, 1'b0, '0, '0);
        add_row('0, '0, 1'b0, 1'b0, '0, '0);
        add_row(32'sh0000_ffff, 32'shffff_0000, 1'b0, 1'b0, '0, '0);
        add_row(C_MIN, C_MAX, 1'b1, 1'b0, '0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_waypoint(dir_rows[i].x, dir_rows[i].y, dir_rows[i].fin,
                          dir_rows[i].fixed, dir_rows[i].want_x, dir_rows[i].want_y);

        n_rand = 0;
        pidx   = 0;
        while (n_rand < RANDOM_WAYPOINTS)
        begin
            if (pidx == 1)
            begin
                // Stop draining while waypoints keep coming, so that full rises.
                hold_req  = 1'b1;
                rush_left = 40;
            end
            if (pidx == 3)
            begin
                push <= 1'b0;
                while (smooth_exp.size() != 0)
                    @(posedge clk);
            end
            case ($urandom_range(0, 9))
                0, 1: plen = $urandom_range(1, 3);
                9: plen = $urandom_range(17, 40);
                default: plen = $urandom_range(4, 16);
            endcase
            for (int i = 0; i < plen; i++)
            begin
                walk_x = next_coord(walk_x);
                walk_y = next_coord(walk_y);
                wx     = walk_x;
                wy     = walk_y;
                if (i == plen - 1 && plen >= 5 && ctl_count > 0
                    && $urandom_range(0, 2) == 0)
                begin
                    wx = ctl_win[2].x;
                    wy = ctl_win[2].y;
                end
                send_waypoint(wx, wy, 1'(i == plen - 1), 1'b0, '0, '0);
                n_rand++;
            end
            pidx++;
        end

        push <= 1'b0;
        while (smooth_exp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d waypoints in %0d paths (short, repeated-final and saturating",
                 n_waypoints, n_paths);
        $display("cases included); compared %0d smoothed points, %0d mismatches.",
                 n_checked, errors);
        if (errors == 0)
            $display("PASS catmull_rom_path_smoother_unit");
        else
            $display("FAIL catmull_rom_path_smoother_unit");
        $finish;
    end

endmodule

[filelist.f]
src/crps_pkg.sv
src/crps_front.sv
src/crps_jobq.sv
src/crps_back.sv
src/crps_outq.sv
src/catmull_rom_path_smoother_unit.sv
dv/catmull_rom_path_smoother_unit_test.sv
